// ===== sv/pcb_pkg.sv =====
// pcb_pkg: shared types and constants of the pretrigger capture buffer
// depends on nothing; used by pcb_cfg, pcb_ctrl, pcb_datapath and the top module

package pcb_pkg;

    // default sizing
    localparam int DEPTH_DEF       = 1024;
    localparam int SAMPLE_BITS_DEF = 64;

    // fixed field widths
    localparam int CNT_W    = 11;
    localparam int MAXR_W   = 12;
    localparam int SAMPLE_W = 64;
    localparam int IDX_W    = 11;
    localparam int OP_W     = 2;
    localparam int MODE_W   = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_TRIG  = 2'd1;
    localparam logic [OP_W-1:0] OP_REARM = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // capture modes
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FROZEN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READY   = 2'd2;

    // register map
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam logic [1:0] REG_PRE  = 2'd0;
    localparam logic [1:0] REG_POST = 2'd1;
    localparam logic [1:0] REG_MAXR = 2'd2;

    localparam logic [CNT_W-1:0]  PRE_RESET  = 11'd672;
    localparam logic [CNT_W-1:0]  POST_RESET = 11'd78;
    localparam logic [MAXR_W-1:0] MAXR_RESET = 12'd1024;

    // stream layout
    localparam int S_TDATA_W = 80;
    localparam int S_IDX_LSB = SAMPLE_W;
    localparam int M_TDATA_W = 112;
    localparam int M_READ_OK_BIT = MODE_W + 4 * CNT_W;
    localparam int M_DATA_LSB    = M_READ_OK_BIT + 1;
    localparam int M_DATA_MSB    = M_DATA_LSB + SAMPLE_W - 1;

    typedef struct packed {
        logic [CNT_W-1:0]  pre;
        logic [CNT_W-1:0]  post;
        logic [MAXR_W-1:0] max_read;
    } pcb_cfg_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic div_start;
        logic div_sel_post;
        logic load_pre;
        logic load_post;
        logic out_load;
    } pcb_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_scale;
        logic div_done;
        logic out_free;
    } pcb_status_t;

endpackage

// ===== sv/pcb_ram.sv =====
// pcb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module pcb_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pcb_cfg.sv =====
// pcb_cfg: apb register file holding pre, post and max_read settings
// depends on pcb_pkg

module pcb_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcb_pkg::APB_AW-1:0]  paddr,
    input  logic [pcb_pkg::APB_DW-1:0]  pwdata,
    output logic [pcb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output pcb_pkg::pcb_cfg_t           cfg
);

    pcb_pkg::pcb_cfg_t cfg_reg;
    pcb_pkg::pcb_cfg_t cfg_next;
    logic              wr_en;
    logic [1:0]        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                pcb_pkg::REG_PRE:  cfg_next.pre      = pwdata[pcb_pkg::CNT_W-1:0];
                pcb_pkg::REG_POST: cfg_next.post     = pwdata[pcb_pkg::CNT_W-1:0];
                pcb_pkg::REG_MAXR: cfg_next.max_read = pwdata[pcb_pkg::MAXR_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pre      <= pcb_pkg::PRE_RESET;
            cfg_reg.post     <= pcb_pkg::POST_RESET;
            cfg_reg.max_read <= pcb_pkg::MAXR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_sel)
            pcb_pkg::REG_PRE:  prdata = pcb_pkg::APB_DW'(cfg_reg.pre);
            pcb_pkg::REG_POST: prdata = pcb_pkg::APB_DW'(cfg_reg.post);
            pcb_pkg::REG_MAXR: prdata = pcb_pkg::APB_DW'(cfg_reg.max_read);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/pcb_datapath.sv =====
// pcb_datapath: capture state, sample ring, shared divider and result register
// depends on pcb_pkg and pcb_ram

module pcb_datapath #(
    parameter int DEPTH       = pcb_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = pcb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pcb_pkg::pcb_cmd_t              cmd,
    output pcb_pkg::pcb_status_t           status,
    input  pcb_pkg::pcb_cfg_t              cfg,
    input  logic [pcb_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [pcb_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcb_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CNT_W  = pcb_pkg::CNT_W;
    localparam int AW     = $clog2(DEPTH);
    localparam int DW     = $clog2(DEPTH + 1);
    localparam int NUM_W  = CNT_W + DW;
    localparam int QC_W   = $clog2(NUM_W + 1);
    localparam int SW     = ((DW > CNT_W) ? DW : CNT_W) + 1;
    localparam int CMP_W  = (DW > pcb_pkg::MAXR_W) ? DW : pcb_pkg::MAXR_W;
    localparam int REM_W  = pcb_pkg::MAXR_W;

    // input fields
    logic [pcb_pkg::OP_W-1:0]     op;
    logic [pcb_pkg::SAMPLE_W-1:0] sample;
    logic [pcb_pkg::IDX_W-1:0]    idx;

    assign op     = s_tuser;
    assign sample = s_tdata[pcb_pkg::SAMPLE_W-1:0];
    assign idx    = s_tdata[pcb_pkg::S_IDX_LSB +: pcb_pkg::IDX_W];

    // capture state
    logic [pcb_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic [AW-1:0]              trig_reg, trig_next;
    logic [AW-1:0]              post_ptr_reg, post_ptr_next;
    logic [AW-1:0]              start_reg;
    logic [AW-1:0]              clr_reg;
    logic [CNT_W-1:0]           eff_pre_reg, eff_pre_next;
    logic [CNT_W-1:0]           eff_post_reg, eff_post_next;
    logic [CNT_W-1:0]           post_cnt_reg, post_cnt_next;
    logic [DW-1:0]              fresh_reg, fresh_next;
    logic [DW-1:0]              fresh_at_reg, fresh_at_next;
    logic                       rd_ok_reg;

    // divider
    logic [NUM_W-1:0] div_num_reg;
    logic [REM_W-1:0] div_rem_reg;
    logic [QC_W-1:0]  div_cnt_reg;
    logic [REM_W:0]   div_rem_sh;
    logic             div_fit;
    logic [REM_W-1:0] req_sum;

    // result register
    logic                          out_valid_reg;
    logic [pcb_pkg::M_TDATA_W-1:0] out_data_reg;

    logic is_push, is_trig, is_rearm, is_read;
    logic running, frozen, post_room;
    logic wr_run, wr_post;
    logic [AW-1:0] wp_inc, post_ptr_inc;
    logic [pcb_pkg::MAXR_W-1:0] burst_sum, burst_len;
    logic [SW-1:0] vpre;
    logic [SW-1:0] st_diff, st_wrap;
    logic [SW-1:0] ra_sum, ra_wrap;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
    logic [pcb_pkg::SAMPLE_W-1:0] rd_data;

    assign is_push  = cmd.accept && (op == pcb_pkg::OP_PUSH);
    assign is_trig  = cmd.accept && (op == pcb_pkg::OP_TRIG);
    assign is_rearm = cmd.accept && (op == pcb_pkg::OP_REARM);
    assign is_read  = cmd.accept && (op == pcb_pkg::OP_READ);

    assign running   = (mode_reg == pcb_pkg::MODE_RUNNING);
    assign frozen    = (mode_reg == pcb_pkg::MODE_FROZEN);
    assign post_room = (post_cnt_reg < eff_post_reg);
    assign wr_run    = is_push && running;
    assign wr_post   = is_push && frozen && post_room;

    assign wp_inc       = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign post_ptr_inc = (post_ptr_reg == AW'(DEPTH - 1)) ? '0 : post_ptr_reg + 1'b1;

    assign burst_sum = {1'b0, eff_pre_reg} + {1'b0, eff_post_reg};
    assign burst_len = (burst_sum > cfg.max_read) ? cfg.max_read : burst_sum;
    assign vpre = (SW'(fresh_at_reg) >= SW'(eff_pre_reg)) ? SW'(eff_pre_reg)
                                                          : SW'(fresh_at_reg);

    // burst start = trigger - effective pre, modulo ring depth
    assign st_diff = SW'(trig_reg) - SW'(eff_pre_reg);
    assign st_wrap = st_diff[SW-1] ? st_diff + SW'(DEPTH) : st_diff;

    assign ra_sum  = SW'(start_reg) + SW'(idx);
    assign ra_wrap = (ra_sum >= SW'(DEPTH)) ? ra_sum - SW'(DEPTH) : ra_sum;

    assign req_sum = {1'b0, cfg.pre} + {1'b0, cfg.post};

    // ring memory
    assign ram_we    = cmd.clear_en || wr_run || wr_post;
    assign ram_waddr = cmd.clear_en ? clr_reg : (running ? wp_reg : post_ptr_reg);
    assign ram_wdata = cmd.clear_en ? '0 : sample[SAMPLE_BITS-1:0];
    assign ram_re    = is_read;
    assign ram_raddr = ra_wrap[AW-1:0];

    pcb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        mode_next     = mode_reg;
        wp_next       = wp_reg;
        trig_next     = trig_reg;
        post_ptr_next = post_ptr_reg;
        eff_pre_next  = eff_pre_reg;
        eff_post_next = eff_post_reg;
        post_cnt_next = post_cnt_reg;
        fresh_next    = fresh_reg;
        fresh_at_next = fresh_at_reg;

        if (wr_run) begin
            wp_next = wp_inc;
            if (fresh_reg < DW'(DEPTH)) begin
                fresh_next = fresh_reg + 1'b1;
            end
        end
        if (wr_post) begin
            post_ptr_next = post_ptr_inc;
            post_cnt_next = post_cnt_reg + 1'b1;
            if (post_cnt_next == eff_post_reg) begin
                mode_next = pcb_pkg::MODE_READY;
            end
        end
        if (is_trig) begin
            // unscaled values; overwritten by the divider when the sum is too large
            eff_pre_next  = cfg.pre;
            eff_post_next = cfg.post;
            post_cnt_next = '0;
            trig_next     = wp_reg;
            post_ptr_next = wp_reg;
            fresh_at_next = fresh_reg;
            mode_next     = pcb_pkg::MODE_FROZEN;
        end
        if (is_rearm) begin
            mode_next     = pcb_pkg::MODE_RUNNING;
            post_cnt_next = '0;
            fresh_next    = '0;
        end
        if (cmd.load_pre) begin
            eff_pre_next = div_num_reg[CNT_W-1:0];
        end
        if (cmd.load_post) begin
            eff_post_next = div_num_reg[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= pcb_pkg::MODE_RUNNING;
            wp_reg       <= '0;
            trig_reg     <= '0;
            eff_pre_reg  <= '0;
            eff_post_reg <= '0;
            post_cnt_reg <= '0;
            fresh_reg    <= '0;
            fresh_at_reg <= '0;
        end else begin
            mode_reg     <= mode_next;
            wp_reg       <= wp_next;
            trig_reg     <= trig_next;
            eff_pre_reg  <= eff_pre_next;
            eff_post_reg <= eff_post_next;
            post_cnt_reg <= post_cnt_next;
            fresh_reg    <= fresh_next;
            fresh_at_reg <= fresh_at_next;
        end
    end

    always_ff @(posedge aclk) begin
        post_ptr_reg <= post_ptr_next;
        start_reg    <= st_wrap[AW-1:0];
        if (cmd.accept) begin
            rd_ok_reg <= is_read && (pcb_pkg::MAXR_W'(idx) < burst_len);
        end
    end

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign status.clear_last = (clr_reg == AW'(DEPTH - 1));
    assign status.need_scale = (CMP_W'(req_sum) > CMP_W'(DEPTH));

    // restoring divider: x * DEPTH / (pre + post), one quotient bit per cycle
    assign div_rem_sh = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign div_fit    = (div_rem_sh >= {1'b0, req_sum});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= QC_W'(NUM_W);
        end else if (div_cnt_reg != '0) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_num_reg <= NUM_W'(cmd.div_sel_post ? cfg.post : cfg.pre) * NUM_W'(DEPTH);
            div_rem_reg <= '0;
        end else if (div_cnt_reg != '0) begin
            div_num_reg <= {div_num_reg[NUM_W-2:0], div_fit};
            div_rem_reg <= div_fit ? REM_W'(div_rem_sh - {1'b0, req_sum})
                                   : div_rem_sh[REM_W-1:0];
        end
    end

    assign status.div_done = (div_cnt_reg == '0);

    // result register
    assign rd_data = rd_ok_reg ? pcb_pkg::SAMPLE_W'(ram_rdata) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {1'b0, rd_data, rd_ok_reg, vpre[CNT_W-1:0], eff_pre_reg,
                             burst_len[CNT_W-1:0], post_cnt_reg, mode_reg};
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/pcb_ctrl.sv =====
// pcb_ctrl: sequencer for clearing pass, item accept, trigger division and result load
// depends on pcb_pkg

module pcb_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic [pcb_pkg::OP_W-1:0] opcode,
    output logic                     s_tready,
    input  pcb_pkg::pcb_status_t     status,
    output pcb_pkg::pcb_cmd_t        cmd
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DIV_PRE  = 3'd2;
    localparam logic [2:0] ST_DIV_POST = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if ((opcode == pcb_pkg::OP_TRIG) && status.need_scale) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV_PRE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV_PRE: begin
                if (status.div_done) begin
                    cmd.load_pre     = 1'b1;
                    cmd.div_start    = 1'b1;
                    cmd.div_sel_post = 1'b1;
                    state_next       = ST_DIV_POST;
                end
            end
            ST_DIV_POST: begin
                if (status.div_done) begin
                    cmd.load_post = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/pretrigger_capture_buffer_top.sv =====
// pretrigger_capture_buffer_top: trigger capture ring buffer with apb settings
// depends on pcb_pkg, pcb_cfg, pcb_ctrl, pcb_datapath and pcb_ram

// After reset the ring is swept to zero, one entry per cycle, and no item is
// taken until all DEPTH entries are cleared; settings can be written
// meanwhile. For each item the accept cycle does the ring write or issues the
// ring read, and the done state then loads the result register from the
// registered ram output once the output register is free. A trigger whose pre
// plus post exceeds DEPTH adds two back-to-back restoring divisions on one
// shared divider before the result load. A new item is taken while the
// previous result still waits in the output register.

module pretrigger_capture_buffer_top #(
    parameter int DEPTH       = pcb_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = pcb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample_word[63:0], read_index[74:64], zero fill above
    input  logic [pcb_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [pcb_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mode[1:0], post_collected[12:2], burst_length[23:13], trigger_offset[34:24],
    // valid_pre[45:35], read_ok[46], read_data[110:47], zero fill above
    output logic [pcb_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcb_pkg::APB_AW-1:0]     paddr,
    input  logic [pcb_pkg::APB_DW-1:0]     pwdata,
    output logic [pcb_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    pcb_pkg::pcb_cfg_t    cfg;
    pcb_pkg::pcb_cmd_t    cmd;
    pcb_pkg::pcb_status_t status;

    pcb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcb_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one still in work");

    // a result is loaded only when the output register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten");

    // quotients are taken only from a finished division
    a_div_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_pre || cmd.load_post) |-> status.div_done)
        else $error("divider result taken early");

    // a result without read_ok carries no sample
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[pcb_pkg::M_READ_OK_BIT]
        |-> (m_tdata[pcb_pkg::M_DATA_MSB:pcb_pkg::M_DATA_LSB] == '0))
        else $error("read data not zero without read_ok");
`endif

endmodule
